>>> hdl/homopolymer_run_histogram_defines.svh
// Assertion macros used by the checker file.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef HOMOPOLYMER_RUN_HISTOGRAM_DEFINES_SVH
`define HOMOPOLYMER_RUN_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define HRH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define HRH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/hrh_pkg.sv
package hrh_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_RUN_DEF    = 32;
  localparam int COUNT_BITS_DEF = 32;

  // Fixed field widths
  localparam int MODE_W   = 2;
  localparam int SYM_W    = 8;
  localparam int WEIGHT_W = 16;
  localparam int QRUN_W   = 6;
  localparam int OUT_W    = 32;
  localparam int FRAC_W   = 17;
  localparam int Q_BITS   = 16;
  localparam int DIV_CW   = $clog2(Q_BITS);

  // Word modes
  localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // Bin store address sources
  localparam logic [1:0] ADDR_A   = 2'd0;
  localparam logic [1:0] ADDR_B   = 2'd1;
  localparam logic [1:0] ADDR_Q   = 2'd2;
  localparam logic [1:0] ADDR_CLR = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       load;
    logic       push;
    logic       rd_en;
    logic       wr_bin;
    logic       clr_start;
    logic       clr_step;
    logic       rq_load;
    logic       div_step;
    logic [1:0] addr_sel;
  } hrh_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic close_a;
    logic close_b;
    logic pend_b;
    logic trivial;
    logic clr_done;
    logic div_done;
  } hrh_stat_t;

endpackage

>>> hdl/hrh_ctrl.sv
module hrh_ctrl
  import hrh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MODE_W-1:0] in_mode,
  input  hrh_stat_t         stat,
  output hrh_cmd_t          cmd,
  output logic              busy,
  output logic              out_valid
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PUSH = 4'd1;
  localparam logic [3:0] S_RDA  = 4'd2;
  localparam logic [3:0] S_WRA  = 4'd3;
  localparam logic [3:0] S_RDB  = 4'd4;
  localparam logic [3:0] S_WRB  = 4'd5;
  localparam logic [3:0] S_RQ   = 4'd6;
  localparam logic [3:0] S_RQD  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;
  localparam logic [3:0] S_CLR  = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  // Leave reset through a clearing pass over the bin store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decode the state into datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (in_mode)
            MODE_PUSH:  state_nxt = S_PUSH;
            MODE_READ:  state_nxt = S_RQ;
            MODE_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_nxt     = S_CLR;
            end
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_PUSH: begin
        cmd.push = 1'b1;
        if (stat.close_a) begin
          state_nxt = S_RDA;
        end else if (stat.close_b) begin
          state_nxt = S_RDB;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RDA: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = ADDR_A;
        state_nxt    = S_WRA;
      end
      S_WRA: begin
        cmd.wr_bin   = 1'b1;
        cmd.addr_sel = ADDR_A;
        state_nxt    = stat.pend_b ? S_RDB : S_IDLE;
      end
      S_RDB: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = ADDR_B;
        state_nxt    = S_WRB;
      end
      S_WRB: begin
        cmd.wr_bin   = 1'b1;
        cmd.addr_sel = ADDR_B;
        state_nxt    = S_IDLE;
      end
      S_RQ: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = ADDR_Q;
        state_nxt    = S_RQD;
      end
      S_RQD: begin
        cmd.rq_load = 1'b1;
        state_nxt   = stat.trivial ? S_OUT : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = stat.div_done ? S_OUT : S_DIV;
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        cmd.addr_sel = ADDR_CLR;
        state_nxt    = stat.clr_done ? S_IDLE : S_CLR;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

endmodule

>>> hdl/hrh_dp.sv
module hrh_dp
  import hrh_pkg::*;
#(
  parameter int MAX_RUN    = MAX_RUN_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hrh_cmd_t            cmd,
  input  logic [SYM_W-1:0]    in_symbol,
  input  logic                in_last_of_sequence,
  input  logic [WEIGHT_W-1:0] in_weight,
  input  logic [QRUN_W-1:0]   in_query_run,
  output hrh_stat_t           stat,
  output logic [OUT_W-1:0]    out_bin_count,
  output logic [OUT_W-1:0]    out_total_count,
  output logic [FRAC_W-1:0]   out_bin_fraction
);

  localparam int NB = 256 * MAX_RUN;
  localparam int AW = $clog2(NB);
  localparam int RW = $clog2(MAX_RUN + 1);
  localparam int CB = COUNT_BITS;

  // Bin index of a (symbol, run length) pair
  function automatic logic [AW-1:0] bin_idx(input logic [SYM_W-1:0] s,
                                            input logic [RW-1:0]    r);
    return AW'(s) * AW'(MAX_RUN) + AW'(r) - AW'(1);
  endfunction

  // Add a weight and stick at the count maximum
  function automatic logic [CB-1:0] sat_add(input logic [CB-1:0]       a,
                                            input logic [WEIGHT_W-1:0] w);
    logic [CB:0] s;
    s = {1'b0, a} + (CB+1)'(w);
    return s[CB] ? {CB{1'b1}} : s[CB-1:0];
  endfunction

  // Clamp a count to the 32-bit result field
  function automatic logic [OUT_W-1:0] clamp_out(input logic [CB-1:0] v);
    logic [63:0] wide;
    wide = 64'(v);
    return (wide > 64'hFFFF_FFFF) ? {OUT_W{1'b1}} : wide[OUT_W-1:0];
  endfunction

  // Latched input word
  logic [SYM_W-1:0]    sym_r;
  logic                last_r;
  logic [WEIGHT_W-1:0] w_r;
  logic [QRUN_W-1:0]   qrun_r;

  // Open sequence state
  logic [SYM_W-1:0]    prev_sym_r, prev_sym_nxt;
  logic [RW-1:0]       run_r, run_nxt;
  logic                in_seq_r, in_seq_nxt;
  logic [WEIGHT_W-1:0] seq_w_r, seq_w_nxt;
  logic                close_a, close_b;
  logic [AW-1:0]       idx_a_nxt, idx_b_nxt;
  logic [AW-1:0]       idx_a_r, idx_b_r;
  logic                pend_b_r;

  // Bin store and totals
  logic [CB-1:0]       mem [NB];
  logic [CB-1:0]       rdata_r;
  logic [CB-1:0]       total_r;
  logic [AW-1:0]       clr_cnt_r;
  logic [AW-1:0]       addr;
  logic [AW-1:0]       idx_q;
  logic [RW-1:0]       qrun_cl;
  logic                mem_we;
  logic [CB-1:0]       wdata;

  // Read and fraction unit
  logic [CB-1:0]       cnt_r;
  logic [CB-1:0]       rem_r;
  logic [FRAC_W-1:0]   frac_r;
  logic [DIV_CW-1:0]   div_cnt_r;
  logic                q_zero;
  logic [CB-1:0]       cnt_sel;
  logic [CB:0]         rem_x2;
  logic                rem_ge;

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sym_r  <= in_symbol;
      last_r <= in_last_of_sequence;
      w_r    <= in_weight;
      qrun_r <= in_query_run;
    end
  end

  // Work out the run update and the runs that close on this symbol
  always_comb begin
    prev_sym_nxt = prev_sym_r;
    run_nxt      = run_r;
    in_seq_nxt   = in_seq_r;
    seq_w_nxt    = seq_w_r;
    close_a      = 1'b0;
    close_b      = 1'b0;
    idx_a_nxt    = bin_idx(prev_sym_r, run_r);
    if (!in_seq_r) begin
      prev_sym_nxt = sym_r;
      run_nxt      = RW'(1);
      seq_w_nxt    = w_r;
      in_seq_nxt   = 1'b1;
    end else if (sym_r == prev_sym_r) begin
      if (32'(run_r) < MAX_RUN) begin
        run_nxt = run_r + RW'(1);
      end
    end else begin
      close_a      = 1'b1;
      prev_sym_nxt = sym_r;
      run_nxt      = RW'(1);
    end
    idx_b_nxt = bin_idx(prev_sym_nxt, run_nxt);
    if (last_r) begin
      close_b    = 1'b1;
      run_nxt    = '0;
      in_seq_nxt = 1'b0;
    end
  end

  // Hold the sequence state between words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_sym_r <= '0;
      run_r      <= '0;
      in_seq_r   <= 1'b0;
      seq_w_r    <= '0;
      pend_b_r   <= 1'b0;
    end else if (cmd.push) begin
      prev_sym_r <= prev_sym_nxt;
      run_r      <= run_nxt;
      in_seq_r   <= in_seq_nxt;
      seq_w_r    <= seq_w_nxt;
      pend_b_r   <= close_b;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      idx_a_r <= idx_a_nxt;
      idx_b_r <= idx_b_nxt;
    end
  end

  // Pick the bin address for this cycle
  assign q_zero  = (qrun_r == '0);
  assign qrun_cl = (32'(qrun_r) > MAX_RUN) ? RW'(MAX_RUN) : RW'(qrun_r);
  assign idx_q   = q_zero ? '0 : bin_idx(sym_r, qrun_cl);

  always_comb begin
    unique case (cmd.addr_sel)
      ADDR_A:   addr = idx_a_r;
      ADDR_B:   addr = idx_b_r;
      ADDR_Q:   addr = idx_q;
      ADDR_CLR: addr = clr_cnt_r;
      default:  addr = clr_cnt_r;
    endcase
  end

  assign mem_we = cmd.wr_bin | cmd.clr_step;
  assign wdata  = cmd.clr_step ? '0 : sat_add(rdata_r, seq_w_r);

  // Single-port bin store with registered read data
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  // Advance the clearing sweep and keep the grand total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      total_r   <= '0;
    end else begin
      if (cmd.clr_start) begin
        clr_cnt_r <= '0;
        total_r   <= '0;
      end else if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (cmd.wr_bin) begin
        total_r <= sat_add(total_r, seq_w_r);
      end
    end
  end

  // Fraction: settle the easy cases at once, else one quotient bit a cycle
  assign cnt_sel = q_zero ? '0 : rdata_r;
  assign rem_x2  = {rem_r, 1'b0};
  assign rem_ge  = (rem_x2 >= {1'b0, total_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.rq_load) begin
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + DIV_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rq_load) begin
      cnt_r <= cnt_sel;
      rem_r <= cnt_sel;
      if (q_zero || (total_r == '0)) begin
        frac_r <= '0;
      end else if (cnt_sel >= total_r) begin
        frac_r <= FRAC_W'(1) << Q_BITS;
      end else begin
        frac_r <= '0;
      end
    end else if (cmd.div_step) begin
      rem_r  <= rem_ge ? CB'(rem_x2 - {1'b0, total_r}) : rem_x2[CB-1:0];
      frac_r <= {frac_r[FRAC_W-2:0], rem_ge};
    end
  end

  // Report status to the controller
  assign stat.close_a  = close_a;
  assign stat.close_b  = close_b;
  assign stat.pend_b   = pend_b_r;
  assign stat.trivial  = q_zero || (total_r == '0) || (cnt_sel >= total_r);
  assign stat.clr_done = (clr_cnt_r == AW'(NB - 1));
  assign stat.div_done = (div_cnt_r == DIV_CW'(Q_BITS - 1));

  // Drive the result word
  assign out_bin_count    = clamp_out(cnt_r);
  assign out_total_count  = clamp_out(total_r);
  assign out_bin_fraction = frac_r;

endmodule

>>> hdl/homopolymer_run_histogram.sv
// Homopolymer run-length histogram. A word is taken when start is high and busy
// is low; busy stays high until the block can take the next one. A push word
// passes through a push state, plus a read and a write state for each run it
// closes (up to two), because every closed run is a read-modify-write on the
// single-port bin store. A read word reads its bin, then goes straight to the
// result when the query run is zero, the total is zero or the bin holds the
// whole total; else it first runs the restoring divider, which yields one
// quotient bit a cycle. A clear word, and reset itself, sweep the store one bin
// a cycle over all 256 * MAX_RUN bins (8192 at the default). A read result sits
// on the out_ ports for exactly one cycle while out_valid is high and cannot be
// held off, so the receiver must take it in that cycle. Push and clear words
// give no result; mode 3 is dropped.
module homopolymer_run_histogram
  import hrh_pkg::*;
#(
  parameter int MAX_RUN    = MAX_RUN_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [SYM_W-1:0]    in_symbol,
  input  logic                in_last_of_sequence,
  input  logic [WEIGHT_W-1:0] in_weight,
  input  logic [QRUN_W-1:0]   in_query_run,
  output logic                out_valid,
  output logic [OUT_W-1:0]    out_bin_count,
  output logic [OUT_W-1:0]    out_total_count,
  output logic [FRAC_W-1:0]   out_bin_fraction
);

  hrh_cmd_t  cmd;
  hrh_stat_t stat;

  // Sequence the work of each word
  hrh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_mode   (in_mode),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Run tracking, bin store and fraction unit
  hrh_dp #(
    .MAX_RUN    (MAX_RUN),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_symbol           (in_symbol),
    .in_last_of_sequence (in_last_of_sequence),
    .in_weight           (in_weight),
    .in_query_run        (in_query_run),
    .stat                (stat),
    .out_bin_count       (out_bin_count),
    .out_total_count     (out_total_count),
    .out_bin_fraction    (out_bin_fraction)
  );

endmodule

>>> hdl/hrh_checker.sv
`include "homopolymer_run_histogram_defines.svh"

module hrh_checker
  import hrh_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic                out_valid,
  input  logic [OUT_W-1:0]    out_bin_count,
  input  logic [OUT_W-1:0]    out_total_count,
  input  logic [FRAC_W-1:0]   out_bin_fraction
);

  // A result only appears while a read word is still in hand
  `HRH_ASSERT_IMP(a_valid_busy, out_valid, busy, "result strobe without busy")

  // One strobe per read word
  `HRH_ASSERT_NXT(a_single_strobe, out_valid, !out_valid, "result strobe held")

  // An accepted read word keeps the block busy in the next cycle
  `HRH_ASSERT_NXT(a_read_busy, start && !busy && (in_mode == MODE_READ), busy,
    "read word not followed by busy")

  // A bin never exceeds the total, and an empty total gives no fraction
  `HRH_ASSERT_IMP(a_bin_le_total, out_valid, out_bin_count <= out_total_count,
    "bin count above total")

  `HRH_ASSERT_IMP(a_zero_total_frac, out_valid && (out_total_count == '0),
    out_bin_fraction == '0, "fraction non-zero with empty total")

endmodule

bind homopolymer_run_histogram hrh_checker u_hrh_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_mode          (in_mode),
  .out_valid        (out_valid),
  .out_bin_count    (out_bin_count),
  .out_total_count  (out_total_count),
  .out_bin_fraction (out_bin_fraction)
);
